/* design/idfr_pkg.sv */
package idfr_pkg;

    // Width of every vector and direction component on the ports.
    localparam int DATA_W = 16;

    // Default number of fraction bits (Q1.14).
    localparam int FRAC_BITS_DEF = 14;

    // One input transaction: vector to rotate and unit direction.
    typedef struct packed {
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
        logic signed [DATA_W-1:0] dir_x;
        logic signed [DATA_W-1:0] dir_y;
        logic signed [DATA_W-1:0] dir_z;
    } in_item_t;

    // One result transaction: rotated vector and saturation flag.
    typedef struct packed {
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
        logic                     saturated;
    } out_item_t;

endpackage

/* design/idfr_sqrt.sv */
// Pipelined integer square root: one root bit per stage, ROOT_W stages.
// The result is floor(sqrt(rad)).
module idfr_sqrt #(
    parameter int ROOT_W = idfr_pkg::FRAC_BITS_DEF + 1
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [2*ROOT_W-1:0]   rad,
    output logic [ROOT_W-1:0]     root
);

    logic [2*ROOT_W-1:0] rad_reg  [ROOT_W];
    logic [ROOT_W-1:0]   rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_reg [ROOT_W];

    logic [2*ROOT_W-1:0] rad_p     [ROOT_W];
    logic [ROOT_W-1:0]   rem_p     [ROOT_W];
    logic [ROOT_W-1:0]   root_p    [ROOT_W];
    logic [ROOT_W+1:0]   rem_sh    [ROOT_W];
    logic [ROOT_W+1:0]   trial     [ROOT_W];
    logic [ROOT_W+1:0]   rem_next  [ROOT_W];
    logic [ROOT_W-1:0]   root_next [ROOT_W];

    // Each stage brings down the next two radicand bits and tries a one bit.
    always_comb begin
        rad_p[0]  = rad;
        rem_p[0]  = '0;
        root_p[0] = '0;
        for (int k = 1; k < ROOT_W; k++) begin
            rad_p[k]  = rad_reg[k-1];
            rem_p[k]  = rem_reg[k-1];
            root_p[k] = root_reg[k-1];
        end
        for (int k = 0; k < ROOT_W; k++) begin
            rem_sh[k] = {rem_p[k], rad_p[k][2*(ROOT_W-1-k) +: 2]};
            trial[k]  = {root_p[k], 2'b01};
            if (rem_sh[k] >= trial[k]) begin
                rem_next[k]  = rem_sh[k] - trial[k];
                root_next[k] = {root_p[k][ROOT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = rem_sh[k];
                root_next[k] = {root_p[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // The partial remainder of stage k stays below 2^(k+2), so ROOT_W bits
    // carry it into every stage that reads it.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                rad_reg[k]  <= rad_p[k];
                rem_reg[k]  <= rem_next[k][ROOT_W-1:0];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

/* design/idfr_div.sv */
// Pipelined restoring divider for unsigned operands: one quotient bit per
// stage, NUM_W stages. The quotient is truncated. A zero divisor gives a
// meaningless quotient.
module idfr_div #(
    parameter int NUM_W = idfr_pkg::DATA_W + idfr_pkg::FRAC_BITS_DEF + 1,
    parameter int DEN_W = idfr_pkg::FRAC_BITS_DEF + 1
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];

    logic [NUM_W-1:0] num_p    [NUM_W];
    logic [DEN_W-1:0] den_p    [NUM_W];
    logic [DEN_W-1:0] rem_p    [NUM_W];
    logic [NUM_W-1:0] quo_p    [NUM_W];
    logic [DEN_W:0]   rem_sh   [NUM_W];
    logic [DEN_W:0]   rem_next [NUM_W];
    logic [NUM_W-1:0] quo_next [NUM_W];

    // Each stage shifts in one dividend bit and subtracts when it fits.
    always_comb begin
        num_p[0] = num;
        den_p[0] = den;
        rem_p[0] = '0;
        quo_p[0] = '0;
        for (int k = 1; k < NUM_W; k++) begin
            num_p[k] = num_reg[k-1];
            den_p[k] = den_reg[k-1];
            rem_p[k] = rem_reg[k-1];
            quo_p[k] = quo_reg[k-1];
        end
        for (int k = 0; k < NUM_W; k++) begin
            rem_sh[k] = {rem_p[k], num_p[k][NUM_W-1-k]};
            if (rem_sh[k] >= {1'b0, den_p[k]}) begin
                rem_next[k] = rem_sh[k] - {1'b0, den_p[k]};
                quo_next[k] = {quo_p[k][NUM_W-2:0], 1'b1};
            end else begin
                rem_next[k] = rem_sh[k];
                quo_next[k] = {quo_p[k][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_W; k++) begin
                num_reg[k] <= num_p[k];
                den_reg[k] <= den_p[k];
                rem_reg[k] <= rem_next[k][DEN_W-1:0];
                quo_reg[k] <= quo_next[k];
            end
        end
    end

    assign quo = quo_reg[NUM_W-1];

endmodule

/* design/inverse_direction_frame_rotation_core.sv */
// Channel  Direction  Handshake          Payload
// s_       in         s_valid / s_ready  s_data : vector and unit direction
// m_       out        m_valid / m_ready  m_data : rotated vector, saturated flag
//
// One transaction enters per cycle and one result leaves per cycle while the
// output is not stalled. The accepting edge loads the first of four front
// stages, then come the square root (FRACTION_BITS + 1 stages), the dividers
// (DATA_W + FRACTION_BITS + 1 stages), four back stages and the output
// register. The direction is Q1.14 at the default FRACTION_BITS.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
// A stalled output fills a skid register, after which s_ready drops and the
// whole pipeline holds until the skid register drains.
module inverse_direction_frame_rotation_core #(
    parameter int FRACTION_BITS = idfr_pkg::FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  idfr_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output idfr_pkg::out_item_t m_data
);

    import idfr_pkg::*;

    localparam int W      = DATA_W;
    localparam int F      = FRACTION_BITS;
    localparam int UW     = F + 2;
    localparam int AW     = F + 1;
    localparam int SQW    = 2 * F + 2;
    localparam int RW     = F + 1;
    localparam int PW     = W + F + 1;
    localparam int TW     = W + F + 2;
    localparam int MW     = W + F + 1;
    localparam int ZW     = W + F + 3;
    localparam int QZW    = TW + UW;
    localparam int PZW    = W + RW + 1;
    localparam int SW     = QZW + 1;
    localparam int CW     = (W > UW) ? W : UW;
    localparam int SIDE_N = RW + MW;
    localparam int NSTG   = SIDE_N + 8;

    localparam logic signed [CW-1:0] UNIT_POS = CW'(64'sd1 <<< F);
    localparam logic signed [CW-1:0] UNIT_NEG = -UNIT_POS;
    localparam logic signed [SW-1:0] HALF     = SW'(64'sd1 <<< (F - 1));
    localparam logic signed [SW-1:0] SAT_HI   = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO   = -SAT_HI - SW'(1);

    typedef struct packed {
        logic signed [W-1:0]  px;
        logic signed [W-1:0]  py;
        logic signed [W-1:0]  pz;
        logic signed [UW-1:0] ux;
        logic signed [UW-1:0] uy;
        logic signed [UW-1:0] uz;
        logic [AW-1:0]        ax;
        logic [AW-1:0]        ay;
    } st1_t;

    typedef struct packed {
        logic signed [W-1:0]  px;
        logic signed [W-1:0]  py;
        logic signed [W-1:0]  pz;
        logic signed [UW-1:0] uz;
        logic signed [PW-1:0] pxux;
        logic signed [PW-1:0] pyuy;
        logic signed [PW-1:0] pyux;
        logic signed [PW-1:0] pxuy;
        logic signed [PW-1:0] pzuz;
        logic [SQW-1:0]       ax2;
        logic [SQW-1:0]       ay2;
    } st2_t;

    typedef struct packed {
        logic signed [W-1:0]  px;
        logic signed [W-1:0]  py;
        logic signed [W-1:0]  pz;
        logic signed [UW-1:0] uz;
        logic signed [TW-1:0] t;
        logic signed [TW-1:0] yn;
        logic signed [PW-1:0] pzuz;
        logic [SQW-1:0]       up2;
    } st3_t;

    // Data that rides alongside the square root and the divider.
    typedef struct packed {
        logic signed [W-1:0]  px;
        logic signed [W-1:0]  py;
        logic signed [W-1:0]  pz;
        logic signed [UW-1:0] uz;
        logic [MW-1:0]        tmag;
        logic [MW-1:0]        ymag;
        logic                 tneg;
        logic                 yneg;
        logic signed [ZW-1:0] zsum;
        logic                 dzero;
        logic [RW-1:0]        up;
    } side_t;

    typedef struct packed {
        logic signed [W-1:0]  px;
        logic signed [W-1:0]  py;
        logic signed [W-1:0]  pz;
        logic signed [UW-1:0] uz;
        logic signed [TW-1:0] q;
        logic signed [TW-1:0] ny;
        logic signed [ZW-1:0] zsum;
        logic                 dzero;
        logic [RW-1:0]        up;
    } st5_t;

    typedef struct packed {
        logic signed [W-1:0]   px;
        logic signed [W-1:0]   py;
        logic signed [W-1:0]   pz;
        logic                  uzneg;
        logic signed [QZW-1:0] qz;
        logic signed [PZW-1:0] pzup;
        logic signed [TW-1:0]  ny;
        logic signed [ZW-1:0]  zsum;
        logic                  dzero;
    } st6_t;

    typedef struct packed {
        logic signed [W-1:0]   px;
        logic signed [W-1:0]   py;
        logic signed [W-1:0]   pz;
        logic                  uzneg;
        logic signed [QZW-1:0] ra;
        logic signed [PZW-1:0] rb;
        logic signed [ZW-1:0]  rz;
        logic signed [TW-1:0]  ny;
        logic                  dzero;
    } st7_t;

    // Clamp a direction component to [-1, +1].
    function automatic logic signed [UW-1:0] clamp_unit(input logic signed [W-1:0] v);
        logic signed [CW-1:0] e;
        logic signed [CW-1:0] c;
        e = CW'(v);
        if (e > UNIT_POS) begin
            c = UNIT_POS;
        end else if (e < UNIT_NEG) begin
            c = UNIT_NEG;
        end else begin
            c = e;
        end
        return UW'(c);
    endfunction

    // Saturate to the port range; the top bit reports clamping.
    function automatic logic [W:0] sat_w(input logic signed [SW-1:0] v);
        logic [W:0] r;
        if (v > SAT_HI) begin
            r = {1'b1, W'(SAT_HI)};
        end else if (v < SAT_LO) begin
            r = {1'b1, W'(SAT_LO)};
        end else begin
            r = {1'b0, W'(v)};
        end
        return r;
    endfunction

    logic en;
    logic vld_reg [NSTG];

    st1_t  s1_reg, s1_next;
    st2_t  s2_reg, s2_next;
    st3_t  s3_reg, s3_next;
    side_t s4_side_reg, s4_side_next;
    logic [SQW-1:0] s4_up2_reg;
    side_t side_reg [SIDE_N];
    side_t side_next [SIDE_N];
    st5_t  s5_reg, s5_next;
    st6_t  s6_reg, s6_next;
    st7_t  s7_reg, s7_next;
    out_item_t s8_reg, s8_next;

    logic [RW-1:0] root;
    logic [MW-1:0] qt;
    logic [MW-1:0] qy;

    logic signed [TW-1:0] t_abs;
    logic signed [TW-1:0] y_abs;
    logic signed [TW-1:0] qt_s;
    logic signed [TW-1:0] qy_s;
    logic signed [SW-1:0] ra_w;
    logic signed [SW-1:0] rb_w;
    logic signed [SW-1:0] rz_w;
    logic signed [SW-1:0] vx;
    logic signed [SW-1:0] vy;
    logic signed [SW-1:0] vz;
    logic [W:0] sx;
    logic [W:0] sy;
    logic [W:0] sz;

    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;

    // The pipeline advances whenever the skid register is free.
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // Stage 1: clamp the direction and take magnitudes of its x and y.
    always_comb begin
        s1_next.px = s_data.vec_x;
        s1_next.py = s_data.vec_y;
        s1_next.pz = s_data.vec_z;
        s1_next.ux = clamp_unit(s_data.dir_x);
        s1_next.uy = clamp_unit(s_data.dir_y);
        s1_next.uz = clamp_unit(s_data.dir_z);
        s1_next.ax = AW'(s1_next.ux < 0 ? -s1_next.ux : s1_next.ux);
        s1_next.ay = AW'(s1_next.uy < 0 ? -s1_next.uy : s1_next.uy);
    end

    // Stage 2: all products that need only the inputs.
    always_comb begin
        s2_next.px   = s1_reg.px;
        s2_next.py   = s1_reg.py;
        s2_next.pz   = s1_reg.pz;
        s2_next.uz   = s1_reg.uz;
        s2_next.pxux = PW'(s1_reg.px) * PW'(s1_reg.ux);
        s2_next.pyuy = PW'(s1_reg.py) * PW'(s1_reg.uy);
        s2_next.pyux = PW'(s1_reg.py) * PW'(s1_reg.ux);
        s2_next.pxuy = PW'(s1_reg.px) * PW'(s1_reg.uy);
        s2_next.pzuz = PW'(s1_reg.pz) * PW'(s1_reg.uz);
        s2_next.ax2  = SQW'(s1_reg.ax) * SQW'(s1_reg.ax);
        s2_next.ay2  = SQW'(s1_reg.ay) * SQW'(s1_reg.ay);
    end

    // Stage 3: the xy dot and cross products and the squared radius in the xy plane.
    always_comb begin
        s3_next.px   = s2_reg.px;
        s3_next.py   = s2_reg.py;
        s3_next.pz   = s2_reg.pz;
        s3_next.uz   = s2_reg.uz;
        s3_next.t    = TW'(s2_reg.pxux) + TW'(s2_reg.pyuy);
        s3_next.yn   = TW'(s2_reg.pyux) - TW'(s2_reg.pxuy);
        s3_next.pzuz = s2_reg.pzuz;
        s3_next.up2  = s2_reg.ax2 + s2_reg.ay2;
    end

    // Stage 4: sign and magnitude for the dividers, and the z dot product.
    always_comb begin
        t_abs = s3_reg.t[TW-1] ? -s3_reg.t : s3_reg.t;
        y_abs = s3_reg.yn[TW-1] ? -s3_reg.yn : s3_reg.yn;
        s4_side_next.px    = s3_reg.px;
        s4_side_next.py    = s3_reg.py;
        s4_side_next.pz    = s3_reg.pz;
        s4_side_next.uz    = s3_reg.uz;
        s4_side_next.tmag  = MW'(t_abs);
        s4_side_next.ymag  = MW'(y_abs);
        s4_side_next.tneg  = s3_reg.t[TW-1];
        s4_side_next.yneg  = s3_reg.yn[TW-1];
        s4_side_next.zsum  = ZW'(s3_reg.t) + ZW'(s3_reg.pzuz);
        s4_side_next.dzero = (s3_reg.up2 == '0);
        s4_side_next.up    = '0;
    end

    idfr_sqrt #(
        .ROOT_W (RW)
    ) u_sqrt (
        .aclk (aclk),
        .en   (en),
        .rad  (s4_up2_reg),
        .root (root)
    );

    // Side data follows the square root, then picks up the root and
    // follows the dividers.
    always_comb begin
        side_next[0] = s4_side_reg;
        for (int i = 1; i < SIDE_N; i++) begin
            side_next[i] = side_reg[i-1];
        end
        side_next[RW].up = root;
    end

    idfr_div #(
        .NUM_W (MW),
        .DEN_W (RW)
    ) u_div_x (
        .aclk (aclk),
        .en   (en),
        .num  (side_reg[RW-1].tmag),
        .den  (root),
        .quo  (qt)
    );

    idfr_div #(
        .NUM_W (MW),
        .DEN_W (RW)
    ) u_div_y (
        .aclk (aclk),
        .en   (en),
        .num  (side_reg[RW-1].ymag),
        .den  (root),
        .quo  (qy)
    );

    // Stage 5: restore the quotient signs (truncation toward zero).
    always_comb begin
        qt_s = signed'({1'b0, qt});
        qy_s = signed'({1'b0, qy});
        s5_next.px    = side_reg[SIDE_N-1].px;
        s5_next.py    = side_reg[SIDE_N-1].py;
        s5_next.pz    = side_reg[SIDE_N-1].pz;
        s5_next.uz    = side_reg[SIDE_N-1].uz;
        s5_next.q     = side_reg[SIDE_N-1].tneg ? -qt_s : qt_s;
        s5_next.ny    = side_reg[SIDE_N-1].yneg ? -qy_s : qy_s;
        s5_next.zsum  = side_reg[SIDE_N-1].zsum;
        s5_next.dzero = side_reg[SIDE_N-1].dzero;
        s5_next.up    = side_reg[SIDE_N-1].up;
    end

    // Stage 6: the two products that form out_x.
    always_comb begin
        s6_next.px    = s5_reg.px;
        s6_next.py    = s5_reg.py;
        s6_next.pz    = s5_reg.pz;
        s6_next.uzneg = s5_reg.uz[UW-1];
        s6_next.qz    = QZW'(s5_reg.q) * QZW'(s5_reg.uz);
        s6_next.pzup  = PZW'(s5_reg.pz) * PZW'(signed'({1'b0, s5_reg.up}));
        s6_next.ny    = s5_reg.ny;
        s6_next.zsum  = s5_reg.zsum;
        s6_next.dzero = s5_reg.dzero;
    end

    // Stage 7: round half up back to FRACTION_BITS fraction bits.
    always_comb begin
        ra_w = (SW'(s6_reg.qz) + HALF) >>> F;
        rb_w = (SW'(s6_reg.pzup) + HALF) >>> F;
        rz_w = (SW'(s6_reg.zsum) + HALF) >>> F;
        s7_next.px    = s6_reg.px;
        s7_next.py    = s6_reg.py;
        s7_next.pz    = s6_reg.pz;
        s7_next.uzneg = s6_reg.uzneg;
        s7_next.ra    = QZW'(ra_w);
        s7_next.rb    = PZW'(rb_w);
        s7_next.rz    = ZW'(rz_w);
        s7_next.ny    = s6_reg.ny;
        s7_next.dzero = s6_reg.dzero;
    end

    // Stage 8: pick the case along the z axis, then saturate.
    always_comb begin
        if (s7_reg.dzero) begin
            vy = SW'(s7_reg.py);
            if (s7_reg.uzneg) begin
                vx = -SW'(s7_reg.px);
                vz = -SW'(s7_reg.pz);
            end else begin
                vx = SW'(s7_reg.px);
                vz = SW'(s7_reg.pz);
            end
        end else begin
            vx = SW'(s7_reg.ra) - SW'(s7_reg.rb);
            vy = SW'(s7_reg.ny);
            vz = SW'(s7_reg.rz);
        end
        sx = sat_w(vx);
        sy = sat_w(vy);
        sz = sat_w(vz);
        s8_next.out_x     = sx[W-1:0];
        s8_next.out_y     = sy[W-1:0];
        s8_next.out_z     = sz[W-1:0];
        s8_next.saturated = sx[W] | sy[W] | sz[W];
    end

    // Valid bits move with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTG; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NSTG; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Pipeline data registers.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg      <= s1_next;
            s2_reg      <= s2_next;
            s3_reg      <= s3_next;
            s4_side_reg <= s4_side_next;
            s4_up2_reg  <= s3_reg.up2;
            for (int i = 0; i < SIDE_N; i++) begin
                side_reg[i] <= side_next[i];
            end
            s5_reg <= s5_next;
            s6_reg <= s6_next;
            s7_reg <= s7_next;
            s8_reg <= s8_next;
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= vld_reg[NSTG-1];
                out_data_reg  <= s8_reg;
            end
        end else if (vld_reg[NSTG-1] && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
            skid_data_reg  <= s8_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // The skid register only holds a transaction behind a full output.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register is empty");

    // A finished transaction meeting a stalled output must land in the skid.
    a_skid_catches: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready && !skid_valid_reg && vld_reg[NSTG-1])
        |=> skid_valid_reg)
        else $error("finished transaction not captured by skid register");

    // The skid register fills only when the output was stalled.
    a_skid_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid register filled without an output stall");

endmodule
